>>> rtl/glpe_pkg.sv
// glpe_pkg: shared types, constants and direction tables of the lost point extrapolation unit
// holds the control word layout used by the microcode rom, the datapath and the top level
// no dependencies
`timescale 1ns / 1ps

package glpe_pkg;

  localparam int ROW_W = 6;   // row and column field width
  localparam int CFG_W = 7;   // grid side register width
  localparam int POS_W = 10;  // signed neighbor position, covers side up to 256 plus offsets
  localparam int CNT_W = 4;   // count of used directions, 0..8
  localparam int ST_W  = 2;
  localparam int DIR_W = 4;   // direction counter, top bit marks all eight done

  localparam logic [CFG_W-1:0] GRID_SIDE_RESET = 7'd64;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [ST_W-1:0] STAT_OK       = 2'd0;
  localparam logic [ST_W-1:0] STAT_NOT_LOST = 2'd1;
  localparam logic [ST_W-1:0] STAT_NO_DIR   = 2'd2;

  // program steps
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_CTR,
    S_CHK_CTR,
    S_RD_FAR,
    S_RD_NEAR_ACC,
    S_DIV_INIT,
    S_DIV_STEP,
    S_FINISH,
    S_EMIT
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_CLR_BUSY,
    C_NO_QUERY,
    C_CTR_OUT,
    C_NOT_LOST,
    C_DIR_MORE,
    C_NO_DIR,
    C_DIV_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_CENTER,
    RD_NEAR,
    RD_FAR
  } rd_sel_t;

  typedef enum logic [1:0] {
    SS_KEEP,
    SS_NOT_LOST,
    SS_BY_COUNT
  } st_sel_t;

  typedef struct packed {
    logic    accept;      // input channel open
    logic    clear_wr;    // write zero at the clear counter
    rd_sel_t rd;          // memory read and address source
    logic    init;        // clear sums, count and direction
    logic    latch_near;
    logic    accum;
    logic    div_start;
    logic    finish;
    logic    emit;        // hand the result to the output register
    st_sel_t st;
    cond_t   cond;
    step_t   target;
  } ucode_t;

  typedef struct packed {
    logic clr_busy;
    logic ctr_out;
    logic ctr_not_lost;
    logic dir_more;
    logic no_dir;
    logic div_busy;
  } dp_stat_t;

  // order: up, down, left, right, then the four diagonals
  function automatic logic signed [2:0] dir_drow(input logic [2:0] d);
    logic signed [2:0] v;
    unique case (d) inside
      3'd0, 3'd4, 3'd5: v = -3'sd1;
      3'd1, 3'd6, 3'd7: v = 3'sd1;
      default:          v = 3'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [2:0] dir_dcol(input logic [2:0] d);
    logic signed [2:0] v;
    unique case (d) inside
      3'd2, 3'd4, 3'd6: v = -3'sd1;
      3'd3, 3'd5, 3'd7: v = 3'sd1;
      default:          v = 3'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/glpe_ucode_rom.sv
// glpe_ucode_rom: control program of the lost point extrapolation sequencer
// one control word per step; uses types from glpe_pkg
`timescale 1ns / 1ps

module glpe_ucode_rom import glpe_pkg::*; (
  input  step_t  step,
  output ucode_t ctl
);

  always_comb begin
    ctl        = '0;
    ctl.rd     = RD_NONE;
    ctl.st     = SS_KEEP;
    ctl.cond   = C_ALWAYS;
    ctl.target = S_IDLE;
    unique case (step)
      S_CLEAR: begin
        ctl.clear_wr = 1'b1;
        ctl.cond     = C_CLR_BUSY;
        ctl.target   = S_CLEAR;
      end
      S_IDLE: begin
        // loads are written here and never leave this step
        ctl.accept = 1'b1;
        ctl.cond   = C_NO_QUERY;
        ctl.target = S_IDLE;
      end
      S_RD_CTR: begin
        ctl.rd     = RD_CENTER;
        ctl.init   = 1'b1;
        ctl.st     = SS_NOT_LOST;
        ctl.cond   = C_CTR_OUT;
        ctl.target = S_EMIT;
      end
      S_CHK_CTR: begin
        ctl.rd     = RD_NEAR;
        ctl.cond   = C_NOT_LOST;
        ctl.target = S_EMIT;
      end
      S_RD_FAR: begin
        ctl.rd         = RD_FAR;
        ctl.latch_near = 1'b1;
        ctl.cond       = C_ALWAYS;
        ctl.target     = S_RD_NEAR_ACC;
      end
      S_RD_NEAR_ACC: begin
        ctl.rd     = RD_NEAR;
        ctl.accum  = 1'b1;
        ctl.cond   = C_DIR_MORE;
        ctl.target = S_RD_FAR;
      end
      S_DIV_INIT: begin
        ctl.div_start = 1'b1;
        ctl.st        = SS_BY_COUNT;
        ctl.cond      = C_NO_DIR;
        ctl.target    = S_EMIT;
      end
      S_DIV_STEP: begin
        ctl.cond   = C_DIV_BUSY;
        ctl.target = S_DIV_STEP;
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
        ctl.cond   = C_ALWAYS;
        ctl.target = S_EMIT;
      end
      S_EMIT: begin
        ctl.emit   = 1'b1;
        ctl.cond   = C_ALWAYS;
        ctl.target = S_IDLE;
      end
      default: begin
        ctl.cond   = C_ALWAYS;
        ctl.target = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/glpe_div.sv
// glpe_div: two-lane iterative unsigned divider, two quotient bits per cycle
// divisor is the direction count 1..8; uses constants from glpe_pkg
`timescale 1ns / 1ps

module glpe_div import glpe_pkg::*; #(
  parameter int W = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [W-1:0]     num_a,
  input  logic [W-1:0]     num_b,
  input  logic [CNT_W-1:0] den,
  output logic [W-1:0]     quo_a,
  output logic [W-1:0]     quo_b,
  output logic             busy
);

  localparam int ITER   = W / 2;
  localparam int ITER_W = $clog2(ITER + 1);

  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]      nq_r  [2];
  logic [W-1:0]      nq_nxt[2];
  logic [2:0]        rem_r  [2];
  logic [2:0]        rem_nxt[2];

  // one restoring step: returns quotient bit and new remainder
  function automatic logic [3:0] div_bit(input logic [2:0] rem, input logic nb,
                                         input logic [CNT_W-1:0] d);
    logic [3:0] t;
    logic [3:0] diff;
    t    = {rem, nb};
    diff = t - d;
    if (t >= d) return {1'b1, diff[2:0]};
    return {1'b0, t[2:0]};
  endfunction

  always_comb begin
    logic [3:0] s1;
    logic [3:0] s2;
    for (int l = 0; l < 2; l++) begin
      s1         = div_bit(rem_r[l], nq_r[l][W-1], den);
      s2         = div_bit(s1[2:0], nq_r[l][W-2], den);
      nq_nxt[l]  = {nq_r[l][W-3:0], s1[3], s2[3]};
      rem_nxt[l] = s2[2:0];
    end
    cnt_nxt = cnt_r;
    if (start)           cnt_nxt = ITER_W'(ITER);
    else if (cnt_r != 0) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r[0]  <= num_a;
      nq_r[1]  <= num_b;
      rem_r[0] <= '0;
      rem_r[1] <= '0;
    end else if (cnt_r != 0) begin
      nq_r[0]  <= nq_nxt[0];
      nq_r[1]  <= nq_nxt[1];
      rem_r[0] <= rem_nxt[0];
      rem_r[1] <= rem_nxt[1];
    end
  end

  assign quo_a = nq_r[0];
  assign quo_b = nq_r[1];
  assign busy  = cnt_r != 0;

endmodule

>>> rtl/glpe_datapath.sv
// glpe_datapath: grid memory, neighbor address generation, sums and result formatting
// driven by the control word from glpe_ucode_rom; uses glpe_pkg and glpe_div
`timescale 1ns / 1ps

module glpe_datapath import glpe_pkg::*; #(
  parameter int MAX_SIDE   = 64,
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ucode_t                       ctl,
  input  logic                         in_acc,
  input  logic                         in_opcode,
  input  logic [ROW_W-1:0]             in_row,
  input  logic [ROW_W-1:0]             in_col,
  input  logic signed [COORD_BITS-1:0] in_loc_x,
  input  logic signed [COORD_BITS-1:0] in_loc_y,
  input  logic                         in_is_lost,
  input  logic [CFG_W-1:0]             grid_side,
  output dp_stat_t                     stat,
  output logic [ST_W-1:0]              res_status,
  output logic signed [COORD_BITS-1:0] res_est_x,
  output logic signed [COORD_BITS-1:0] res_est_y,
  output logic [CNT_W-1:0]             res_count
);

  localparam int C      = COORD_BITS;
  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int MEM_W  = 2 * C + 1;
  localparam int ACC_W  = C + 5;
  localparam int DIV_W  = ACC_W + ACC_W % 2;
  localparam logic [POS_W-1:0] MAX_SIDE_P = POS_W'(MAX_SIDE);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic signed [ACC_W-1:0] CMAX = ACC_W'((longint'(1) << (C - 1)) - 1);
  localparam logic signed [ACC_W-1:0] CMIN = ~CMAX;

  // memory word: lost flag, x, y
  logic [MEM_W-1:0]  mem [CELLS];
  logic [MEM_W-1:0]  rd_data_r;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [MEM_W-1:0]  wr_data;
  logic              rd_flag;
  logic [C-1:0]      rd_x, rd_y;

  logic [ADDR_W-1:0] clr_r;
  logic [ROW_W-1:0]  row_r, col_r;
  logic [DIR_W-1:0]  dir_r;
  logic [CNT_W-1:0]  n_r;
  logic [ST_W-1:0]   st_r;
  logic              near_in_r, far_in_r, near_ok_r;
  logic [C-1:0]      near_x_r, near_y_r;
  logic signed [ACC_W-1:0] sx_r, sy_r;
  logic              neg_x_r, neg_y_r;
  logic signed [C-1:0] est_x_r, est_y_r;

  logic [POS_W-1:0]        side;
  logic signed [2:0]       off_r, off_c;
  logic signed [POS_W-1:0] prow, pcol;
  logic                    in_grid;
  logic [POS_W-1:0]        lrow, lcol;
  logic                    in_store;
  logic                    use_dir;
  logic signed [ACC_W-1:0] nx_e, ny_e, fx_e, fy_e;
  logic [ACC_W-1:0]        mag_x, mag_y;
  logic [DIV_W-1:0]        quo_x, quo_y;
  logic                    div_busy;

  // effective side: register value capped at the store size
  assign side = (POS_W'(grid_side) > MAX_SIDE_P) ? MAX_SIDE_P : POS_W'(grid_side);

  always_comb begin
    unique case (ctl.rd)
      RD_NEAR: begin
        off_r = dir_drow(dir_r[2:0]);
        off_c = dir_dcol(dir_r[2:0]);
      end
      RD_FAR: begin
        off_r = dir_drow(dir_r[2:0]) <<< 1;
        off_c = dir_dcol(dir_r[2:0]) <<< 1;
      end
      default: begin
        off_r = 3'sd0;
        off_c = 3'sd0;
      end
    endcase
    prow = $signed({{(POS_W-ROW_W){1'b0}}, row_r}) + $signed({{(POS_W-3){off_r[2]}}, off_r});
    pcol = $signed({{(POS_W-ROW_W){1'b0}}, col_r}) + $signed({{(POS_W-3){off_c[2]}}, off_c});
    in_grid = !prow[POS_W-1] && !pcol[POS_W-1] &&
              (prow[POS_W-1:0] < side) && (pcol[POS_W-1:0] < side);
    rd_addr = in_grid ? ADDR_W'(prow[IDX_W-1:0]) * ADDR_W'(MAX_SIDE) + ADDR_W'(pcol[IDX_W-1:0])
                      : '0;
    rd_en = ctl.rd != RD_NONE;
  end

  // write port: clearing pass or a load transaction
  always_comb begin
    lrow     = POS_W'(in_row);
    lcol     = POS_W'(in_col);
    in_store = (lrow < MAX_SIDE_P) && (lcol < MAX_SIDE_P);
    if (ctl.clear_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else begin
      wr_en   = in_acc && (in_opcode == OP_LOAD) && in_store;
      wr_addr = in_store ? ADDR_W'(lrow[IDX_W-1:0]) * ADDR_W'(MAX_SIDE) + ADDR_W'(lcol[IDX_W-1:0])
                         : '0;
      wr_data = {in_is_lost, in_loc_x, in_loc_y};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_flag = rd_data_r[MEM_W-1];
  assign rd_x    = rd_data_r[2*C-1:C];
  assign rd_y    = rd_data_r[C-1:0];

  always_comb begin
    nx_e    = {{(ACC_W-C){near_x_r[C-1]}}, near_x_r};
    ny_e    = {{(ACC_W-C){near_y_r[C-1]}}, near_y_r};
    fx_e    = {{(ACC_W-C){rd_x[C-1]}}, rd_x};
    fy_e    = {{(ACC_W-C){rd_y[C-1]}}, rd_y};
    use_dir = near_ok_r && far_in_r && !rd_flag;
    mag_x   = sx_r[ACC_W-1] ? ACC_W'(-sx_r) : ACC_W'(sx_r);
    mag_y   = sy_r[ACC_W-1] ? ACC_W'(-sy_r) : ACC_W'(sy_r);
  end

  glpe_div #(.W(DIV_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num_a (DIV_W'(mag_x)),
    .num_b (DIV_W'(mag_y)),
    .den   (n_r),
    .quo_a (quo_x),
    .quo_b (quo_y),
    .busy  (div_busy)
  );

  // restore the sign and clamp to the coordinate range
  function automatic logic signed [C-1:0] sat_q(input logic [DIV_W-1:0] q, input logic neg);
    logic signed [ACC_W-1:0] v;
    v = neg ? -$signed(q[ACC_W-1:0]) : $signed(q[ACC_W-1:0]);
    if (v > CMAX) return CMAX[C-1:0];
    if (v < CMIN) return CMIN[C-1:0];
    return v[C-1:0];
  endfunction

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      dir_r <= '0;
      n_r   <= '0;
      st_r  <= STAT_NOT_LOST;
    end else begin
      if (ctl.clear_wr) clr_r <= clr_r + 1'b1;
      if (ctl.init) begin
        dir_r <= '0;
        n_r   <= '0;
      end else begin
        if (ctl.rd == RD_FAR) dir_r <= dir_r + 1'b1;
        if (ctl.accum && use_dir) n_r <= n_r + 1'b1;
      end
      unique case (ctl.st)
        SS_NOT_LOST: st_r <= STAT_NOT_LOST;
        SS_BY_COUNT: st_r <= (n_r == 0) ? STAT_NO_DIR : STAT_OK;
        default:     st_r <= st_r;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (ctl.rd == RD_NEAR) near_in_r <= in_grid;
    if (ctl.rd == RD_FAR)  far_in_r  <= in_grid;
    if (ctl.latch_near) begin
      near_ok_r <= near_in_r && !rd_flag;
      near_x_r  <= rd_x;
      near_y_r  <= rd_y;
    end
    if (ctl.init) begin
      sx_r <= '0;
      sy_r <= '0;
    end else if (ctl.accum && use_dir) begin
      sx_r <= sx_r + (nx_e <<< 1) - fx_e;
      sy_r <= sy_r + (ny_e <<< 1) - fy_e;
    end
    if (ctl.div_start) begin
      neg_x_r <= sx_r[ACC_W-1];
      neg_y_r <= sy_r[ACC_W-1];
    end
    if (ctl.finish) begin
      est_x_r <= sat_q(quo_x, neg_x_r);
      est_y_r <= sat_q(quo_y, neg_y_r);
    end
  end

  always_comb begin
    stat.clr_busy     = clr_r != LAST_ADDR;
    stat.ctr_out      = !in_grid;
    stat.ctr_not_lost = !rd_flag;
    stat.dir_more     = !dir_r[DIR_W-1];
    stat.no_dir       = n_r == 0;
    stat.div_busy     = div_busy;
  end

  assign res_status = st_r;
  assign res_est_x  = (st_r == STAT_OK) ? est_x_r : '0;
  assign res_est_y  = (st_r == STAT_OK) ? est_y_r : '0;
  assign res_count  = n_r;

endmodule

>>> rtl/grid_lost_point_extrapolation_unit.sv
// grid_lost_point_extrapolation_unit: top level, step counter, jump logic and output register
// depends on glpe_pkg, glpe_ucode_rom and glpe_datapath
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   in_     | input     | in_valid/in_stall  | opcode, row, col, loc_x, loc_y, is_lost
//   out_    | output    | out_valid/out_stall| status, est_x, est_y, used_count
//   cfg_    | input     | cfg_wr_en          | cfg_wr_data (grid side)
//
// a load is written in the idle step. a query on a cell outside the grid or not lost goes
// straight to the emit step; with no usable direction it skips the divider; otherwise it divides.
// the query time is set by the single read port of the grid memory (two reads per direction) and
// the divider retiring two quotient bits a cycle.
// after reset a clearing pass writes every grid entry while in_stall stays high. a stalled
// output holds the sequencer in its emit step.
`timescale 1ns / 1ps

module grid_lost_point_extrapolation_unit import glpe_pkg::*; #(
  parameter int MAX_SIDE   = 64,
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [CFG_W-1:0]             cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [ROW_W-1:0]             in_row,
  input  logic [ROW_W-1:0]             in_col,
  input  logic signed [COORD_BITS-1:0] in_loc_x,
  input  logic signed [COORD_BITS-1:0] in_loc_y,
  input  logic                         in_is_lost,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ST_W-1:0]              out_status,
  output logic signed [COORD_BITS-1:0] out_est_x,
  output logic signed [COORD_BITS-1:0] out_est_y,
  output logic [CNT_W-1:0]             out_used_count
);

  step_t    pc_r, pc_nxt;
  ucode_t   ctl;
  dp_stat_t stat;
  logic     in_acc;
  logic     take;
  logic     out_hold;
  logic [CFG_W-1:0] grid_side_r;
  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic signed [COORD_BITS-1:0] out_est_x_r, out_est_y_r;
  logic [CNT_W-1:0] out_count_r;
  logic [ST_W-1:0]  res_status;
  logic signed [COORD_BITS-1:0] res_est_x, res_est_y;
  logic [CNT_W-1:0] res_count;

  glpe_ucode_rom u_rom (
    .step (pc_r),
    .ctl  (ctl)
  );

  assign in_stall = !ctl.accept;
  assign in_acc   = in_valid && ctl.accept;
  assign out_hold = out_valid_r && out_stall;

  glpe_datapath #(
    .MAX_SIDE   (MAX_SIDE),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_acc     (in_acc),
    .in_opcode  (in_opcode),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_loc_x   (in_loc_x),
    .in_loc_y   (in_loc_y),
    .in_is_lost (in_is_lost),
    .grid_side  (grid_side_r),
    .stat       (stat),
    .res_status (res_status),
    .res_est_x  (res_est_x),
    .res_est_y  (res_est_y),
    .res_count  (res_count)
  );

  always_comb begin
    unique case (ctl.cond)
      C_CLR_BUSY: take = stat.clr_busy;
      C_NO_QUERY: take = !(in_valid && (in_opcode == OP_QUERY));
      C_CTR_OUT:  take = stat.ctr_out;
      C_NOT_LOST: take = stat.ctr_not_lost;
      C_DIR_MORE: take = stat.dir_more;
      C_NO_DIR:   take = stat.no_dir;
      C_DIV_BUSY: take = stat.div_busy;
      default:    take = 1'b1;
    endcase
    pc_nxt = take ? ctl.target : step_t'(pc_r + 1'b1);
    // wait for room in the output register
    if (ctl.emit && out_hold) pc_nxt = pc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_CLEAR;
      grid_side_r <= GRID_SIDE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_wr_en) grid_side_r <= cfg_wr_data;
      if (ctl.emit && !out_hold)  out_valid_r <= 1'b1;
      else if (!out_stall)        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && !out_hold) begin
      out_status_r <= res_status;
      out_est_x_r  <= res_est_x;
      out_est_y_r  <= res_est_y;
      out_count_r  <= res_count;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_est_x      = out_est_x_r;
  assign out_est_y      = out_est_y_r;
  assign out_used_count = out_count_r;

  // a query transaction closes the input until its result is out
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode == OP_QUERY) |=> in_stall)
    else $error("input taken while a query is in progress");

  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_CLEAR) |-> in_stall)
    else $error("input open during the clearing pass");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && !out_hold && res_status == STAT_OK) |=>
      (out_used_count != 0 && out_used_count <= 4'd8))
    else $error("estimate issued with a bad direction count");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_DIV_STEP) |-> (res_count != 0))
    else $error("divider running with a zero count");

endmodule
